>>> rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Request and result payloads, configuration register indexes and sizes.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_PATTERN  = 16;  // longest pattern, 1..16
  localparam int ADDRESS_BITS = 48;  // address width, 32..64

  // Width that holds 0..MAX_PATTERN (length and window fill)
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  // Width of an index into MAX_PATTERN bytes
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // Stored history bytes (one spare keeps the array non-empty)
  localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_WANT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_CARE    = 3'd5;

  typedef struct packed {
    logic [7:0]              data_byte;
    logic [ADDRESS_BITS-1:0] byte_address;
    logic [3:0]              region_perms;
    logic                    region_first;
    logic                    scan_last;
  } scan_req_t;

  typedef struct packed {
    logic                    found;
    logic [ADDRESS_BITS-1:0] match_address;
  } scan_result_t;

endpackage

>>> rtl/core/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner: streaming wildcard byte pattern search
// Scans memory bytes region by region and reports the first pattern match.
// ----------------------------------------------------------------------------
// Usage
//   Requests (one memory byte each, with its address, region flags and
//   region/scan markers) enter on scan_valid/scan_ready. Results leave on
//   result_valid/result_ready: one for a scan's first match, or one not-found
//   on the last byte of a scan with no match. Most requests produce no result.
//   Configuration is written through cfg_write/cfg_index/cfg_data while the
//   block is idle; writes take effect at once, unknown indexes are dropped.
// Timing
//   A request is held in the input register, then its compare and window
//   update happen in one pass into the result register; a held result can
//   keep it waiting in the input register. One request per cycle is sustained
//   while results are taken; the 16-way masked byte compare sets the cycle.
// Reset
//   rst (synchronous) empties both registers, clears the window fill,
//   deselects the region, rearms the scan and loads register defaults.
// Stall
//   A held result stops the input register whenever it holds a request;
//   scan_ready drops until result_ready frees the slot.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                scan_valid,
  output logic                                scan_ready,
  input  wbps_pkg::scan_req_t                 scan_item,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output wbps_pkg::scan_result_t              result
);

  localparam int MAXP  = wbps_pkg::MAX_PATTERN;
  localparam int LEN_W = wbps_pkg::LEN_W;
  localparam int IDX_W = wbps_pkg::IDX_W;
  localparam int WIN_D = wbps_pkg::WIN_DEPTH;
  localparam int AW    = wbps_pkg::ADDRESS_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] pattern_bytes_low;
  logic [63:0] pattern_bytes_high;
  logic [15:0] wildcard_mask;
  logic [4:0]  pattern_length;
  logic [3:0]  perm_want;
  logic [3:0]  perm_care;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      wildcard_mask      <= '0;
      pattern_length     <= 5'd1;
      perm_want          <= 4'd1;
      perm_care          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wbps_pkg::CFG_PATTERN_LOW:  pattern_bytes_low  <= cfg_data;
        wbps_pkg::CFG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        wbps_pkg::CFG_WILDCARD:     wildcard_mask      <= cfg_data[15:0];
        wbps_pkg::CFG_LENGTH:       pattern_length     <= cfg_data[4:0];
        wbps_pkg::CFG_PERM_WANT:    perm_want          <= cfg_data[3:0];
        wbps_pkg::CFG_PERM_CARE:    perm_care          <= cfg_data[3:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Effective length: zero counts as one, long values saturate
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (pattern_length == 5'd0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > 5'(MAXP)) begin
      len_eff = LEN_W'(MAXP);
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  // Pattern bytes as an array
  logic [7:0] pat [MAXP];
  always_comb begin
    for (int i = 0; i < MAXP; i++) begin
      if (i < 8) begin
        pat[i] = pattern_bytes_low[(i % 8) * 8 +: 8];
      end else begin
        pat[i] = pattern_bytes_high[(i % 8) * 8 +: 8];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                stage_valid;
  wbps_pkg::scan_req_t stage;
  logic                advance;

  // Stage moves on when the result slot is free or being emptied
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign scan_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (scan_ready) begin
      stage_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_ready && scan_valid) begin
      stage <= scan_item;
    end
  end

  // --------------------------------------------------------------------------
  // Scan state
  // --------------------------------------------------------------------------
  logic [7:0]       window [WIN_D];   // entry 0 is the most recent byte
  logic [LEN_W-1:0] window_fill;
  logic             region_selected;
  logic             scan_finished;

  logic             perm_ok;
  logic             sel_now;
  logic [LEN_W-1:0] fill_now;
  logic [LEN_W-1:0] fill_next;
  logic [7:0]       cand [MAXP];      // index = bytes back from current
  logic             all_match;
  logic             hit;
  logic             emit;

  assign perm_ok  = ((stage.region_perms ^ perm_want) & perm_care) == 4'd0;
  assign sel_now  = stage.region_first ? perm_ok : region_selected;
  assign fill_now = stage.region_first ? '0 : window_fill;

  always_comb begin
    cand[0] = stage.data_byte;
    for (int j = 1; j < MAXP; j++) begin
      cand[j] = window[j-1];
    end
  end

  // Masked compare: pattern byte i lines up with the byte len-1-i back
  always_comb begin
    logic [LEN_W-1:0] back;
    all_match = 1'b1;
    back      = '0;
    for (int i = 0; i < MAXP; i++) begin
      back = len_eff - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < len_eff) && !wildcard_mask[i]) begin
        if (cand[back[IDX_W-1:0]] != pat[i]) begin
          all_match = 1'b0;
        end
      end
    end
  end

  assign hit  = sel_now && (({1'b0, fill_now} + (LEN_W+1)'(1)) >= {1'b0, len_eff})
                && all_match;
  assign emit = hit || stage.scan_last;

  assign fill_next = (fill_now < LEN_W'(MAXP - 1)) ? fill_now + LEN_W'(1) : fill_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill     <= '0;
      region_selected <= 1'b0;
      scan_finished   <= 1'b0;
    end else if (advance) begin
      if (scan_finished) begin
        // rest of a scan is ignored until its last byte rearms us
        if (stage.scan_last) begin
          scan_finished <= 1'b0;
        end
      end else begin
        region_selected <= sel_now;
        window_fill     <= fill_next;
        scan_finished   <= hit && !stage.scan_last;
      end
    end
  end

  // History shift (payload, no reset: reads stay below the fill)
  always_ff @(posedge clk) begin
    if (advance && !scan_finished && (MAXP > 1)) begin
      window[0] <= stage.data_byte;
      for (int k = 1; k < WIN_D; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && !scan_finished && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !scan_finished && emit) begin
      result.found <= hit;
      if (hit) begin
        result.match_address <= stage.byte_address - AW'(len_eff - LEN_W'(1));
      end else begin
        result.match_address <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.match_address == '0)
    else $error("not-found result with nonzero address");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= LEN_W'(MAXP - 1))
    else $error("window fill beyond history depth");

  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    advance && !scan_finished && stage.scan_last |=> result_valid)
    else $error("armed last byte produced no result");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage))
    else $error("stalled request lost from input register");

  a_finished_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && scan_finished |=> !result_valid)
    else $error("ignored byte produced a result");

endmodule
